@@ rtl/wcapf_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types for the WCA pair force block.
// No dependencies; every other file of the block imports this package.
package wcapf_pkg;

    // Fixed-point formats
    localparam int POS_FRAC_BITS = 24;
    localparam int POS_W         = 32;
    localparam int BOX_W         = 32;
    localparam int OUT_W         = 32;
    localparam int WRAP_W        = POS_W + 2;
    localparam int SQ_W          = 2 * POS_W;

    // r2 is Q.2P; the squared cutoff 2^(1/3) is held in Q2.30 and lifted to Q.2P
    localparam int R2_SHIFT             = 2 * POS_FRAC_BITS - 30;
    localparam int R30_W                = 31;
    localparam logic [SQ_W-1:0] CUT2_R2 = SQ_W'(64'd1352829926) << R2_SHIFT;
    localparam logic [R30_W-1:0] SMALL_R30 = R30_W'(32'd16777216);

    // Reciprocal s = 2^62 / r30 by long division, one quotient bit per stage
    localparam int DIV_STEPS             = 38;
    localparam int REM_W                 = 32;
    localparam logic [REM_W-1:0] DIV_REM0 = REM_W'(32'd16777216);
    localparam int S_W                   = DIV_STEPS + 1;
    localparam logic [S_W-1:0] S_CLAMP   = S_W'(1) << DIV_STEPS;

    // Multiplier operand and product widths
    localparam int MUL_W  = 64;
    localparam int PROD_W = 2 * MUL_W;
    localparam int UM_W   = 52;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_X = 2'd0,
        CFG_BOX_Y = 2'd1,
        CFG_BOX_Z = 2'd2
    } t_cfg_idx;
    localparam logic [BOX_W-1:0] BOX_RESET = 32'd167772160;

    // Classified pair as handed from the front to the back
    typedef struct packed {
        logic [2:0][POS_W-1:0] mag;
        logic [2:0]            wneg;
        logic                  cut;
        logic                  tiny;
        logic [R30_W-1:0]      r30;
    } t_qent;

    // Per-pair data carried down the back pipeline
    typedef struct packed {
        logic [2:0][POS_W-1:0] mag;
        logic [2:0]            wneg;
        logic                  cut;
        logic                  tiny;
        logic                  uneg;
        logic [OUT_W-1:0]      energy;
        logic                  eclip;
    } t_pl;

endpackage

@@ rtl/wcapf_in_if.sv @@
`timescale 1ns / 1ps
// Input channel: one pair difference per beat, valid/ready handshake.
// Depends on wcapf_pkg.
interface wcapf_in_if import wcapf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] dx;
    logic signed [POS_W-1:0] dy;
    logic signed [POS_W-1:0] dz;

    modport source (output valid, dx, dy, dz, input ready);
    modport sink   (input valid, dx, dy, dz, output ready);
endinterface

@@ rtl/wcapf_out_if.sv @@
`timescale 1ns / 1ps
// Output channel: force, energy and flags of one pair per beat.
// Depends on wcapf_pkg.
interface wcapf_out_if import wcapf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] force_x;
    logic signed [OUT_W-1:0] force_y;
    logic signed [OUT_W-1:0] force_z;
    logic [OUT_W-1:0]        pair_energy;
    logic                    in_cutoff;
    logic                    clipped;

    modport source (output valid, force_x, force_y, force_z, pair_energy, in_cutoff,
                    clipped, input ready);
    modport sink   (input valid, force_x, force_y, force_z, pair_energy, in_cutoff,
                    clipped, output ready);
endinterface

@@ rtl/wcapf_mul.sv @@
`timescale 1ns / 1ps
// 64x64 unsigned multiplier built from four 32x32 partial products.
// Two register stages sharing one enable. Depends on wcapf_pkg.
module wcapf_mul import wcapf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [MUL_W-1:0]  i_a,
    input  logic [MUL_W-1:0]  i_b,
    output logic [PROD_W-1:0] o_p
);
    logic [MUL_W-1:0]  r_ll, r_lh, r_hl, r_hh;
    logic [PROD_W-1:0] r_p;

    // stage 1: partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= MUL_W'(i_a[31:0])  * MUL_W'(i_b[31:0]);
            r_lh <= MUL_W'(i_a[31:0])  * MUL_W'(i_b[63:32]);
            r_hl <= MUL_W'(i_a[63:32]) * MUL_W'(i_b[31:0]);
            r_hh <= MUL_W'(i_a[63:32]) * MUL_W'(i_b[63:32]);
        end
    end

    // stage 2: alignment and sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= {r_hh, r_ll} + {32'b0, r_lh, 32'b0} + {32'b0, r_hl, 32'b0};
        end
    end

    assign o_p = r_p;
endmodule

@@ rtl/wcapf_front.sv @@
`timescale 1ns / 1ps
// Front end: box registers, minimum-image wrap, squared distance, cutoff test.
// Pushes one classified pair per cycle unless the queue is full. Depends on wcapf_pkg, wcapf_in_if.
module wcapf_front import wcapf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BOX_W-1:0]     i_cfg_data,
    wcapf_in_if.sink             i_in,
    output logic                 o_push,
    output t_qent                o_qent,
    input  logic                 i_q_full
);
    logic [2:0][BOX_W-1:0]  r_box;
    logic                   r_v1, r_v2, r_v3, r_v4;
    logic                   en, acc;
    logic [2:0][POS_W-1:0]  w_d;
    logic [2:0][WRAP_W-1:0] n_w, r_w, w_negw;
    logic [2:0][POS_W-1:0]  r_mag2, r_mag3;
    logic [2:0]             r_neg2, r_neg3;
    logic [2:0][SQ_W-1:0]   r_sq3;
    logic [SQ_W-1:0]        w_r2;
    logic [R30_W-1:0]       w_r30;
    t_qent                  r_qent;

    // box edge registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box <= {3{BOX_RESET}};
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_BOX_X: r_box[0] <= i_cfg_data;
                CFG_BOX_Y: r_box[1] <= i_cfg_data;
                CFG_BOX_Z: r_box[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // whole front advances unless the last stage is blocked by a full queue
    assign en         = !r_v4 || !i_q_full;
    assign acc        = i_in.valid && en;
    assign i_in.ready = en;

    assign w_d[0] = i_in.dx;
    assign w_d[1] = i_in.dy;
    assign w_d[2] = i_in.dz;

    // wrap once: subtract the box if 2d > box, add it if 2d < -box
    always_comb begin
        logic [WRAP_W-1:0] dext, d2, b;
        logic              gt, lt;
        for (int c = 0; c < 3; c++) begin
            dext   = {{2{w_d[c][POS_W-1]}}, w_d[c]};
            d2     = {w_d[c][POS_W-1], w_d[c], 1'b0};
            b      = {2'b00, r_box[c]};
            gt     = $signed(d2) > $signed(b);
            lt     = $signed(d2) < -$signed(b);
            n_w[c] = gt ? dext - b : (lt ? dext + b : dext);
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_negw[c] = -r_w[c];
        end
    end

    // squared distance, cutoff and scaled r2
    assign w_r2  = r_sq3[0] + r_sq3[1] + r_sq3[2];
    assign w_r30 = w_r2[R2_SHIFT +: R30_W];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w <= n_w;
            for (int c = 0; c < 3; c++) begin
                r_mag2[c] <= r_w[c][WRAP_W-1] ? w_negw[c][POS_W-1:0] : r_w[c][POS_W-1:0];
                r_neg2[c] <= r_w[c][WRAP_W-1];
                r_sq3[c]  <= SQ_W'(r_mag2[c]) * SQ_W'(r_mag2[c]);
            end
            r_mag3       <= r_mag2;
            r_neg3       <= r_neg2;
            r_qent.mag   <= r_mag3;
            r_qent.wneg  <= r_neg3;
            r_qent.cut   <= w_r2 < CUT2_R2;
            r_qent.tiny  <= w_r30 <= SMALL_R30;
            r_qent.r30   <= w_r30;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= acc;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign o_push = r_v4 && !i_q_full;
    assign o_qent = r_qent;
endmodule

@@ rtl/wcapf_queue.sv @@
`timescale 1ns / 1ps
// Short FIFO between front and back so that each side stalls on its own.
// Depends on wcapf_pkg.
module wcapf_queue import wcapf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_qent,
    output logic  o_full,
    output logic  o_valid,
    output t_qent o_qent,
    input  logic  i_pop
);
    t_qent              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wp, r_rp;
    logic [QCNT_W-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_qent;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_full  = r_cnt == QCNT_W'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_qent  = r_mem[r_rp];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("queue pop while empty");
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        QPTR_W'(r_wp - r_rp) == r_cnt[QPTR_W-1:0])
        else $error("queue pointers disagree with fill count");
endmodule

@@ rtl/wcapf_back.sv @@
`timescale 1ns / 1ps
// Back end: reciprocal divider, power chain, energy, force scaling and saturation.
// Ends in the output register. Depends on wcapf_pkg, wcapf_mul, wcapf_out_if.
module wcapf_back import wcapf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_qent     i_qent,
    output logic      o_pop,
    wcapf_out_if.source o_out
);
    localparam int ST_S    = DIV_STEPS + 1;  // s selected
    localparam int ST_U    = ST_S + 5;       // |u| and s^4 registered
    localparam int ST_G    = ST_U + 3;       // G and energy registered
    localparam int ST_LAST = ST_G + 2;       // force products ready

    logic                 en;
    t_pl                  r_pl [ST_LAST+1];
    t_pl                  n_pl [ST_LAST+1];
    logic [ST_LAST:0]     r_v;
    logic [REM_W-1:0]     r_rem [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] r_quo [DIV_STEPS+1];
    logic [R30_W-1:0]     r_den [DIV_STEPS+1];
    logic [S_W-1:0]       r_s, r_sd1, r_sd2;
    logic [PROD_W-1:0]    w_pa, w_pb, w_pc, w_pd, w_pe;
    logic [2:0][PROD_W-1:0] w_pf;
    logic [MUL_W-1:0]     w_s2, w_s3, w_s4, w_s3x2, w_um, w_t;
    logic                 w_uneg;
    logic [UM_W-1:0]      r_um;
    logic [MUL_W-1:0]     r_s4, r_g;
    logic                 w_eclip;
    logic [2:0][PROD_W-1:0] w_mhi;
    logic [2:0][OUT_W-1:0]  n_force, r_force;
    logic                 n_clip;
    logic                 r_ovalid, r_cut, r_clip;
    logic [OUT_W-1:0]     r_energy;

    // whole back advances while the output register can move
    assign en    = !r_ovalid || o_out.ready;
    assign o_pop = en && i_q_valid;

    // divider entry
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem[0] <= DIV_REM0;
            r_quo[0] <= '0;
            r_den[0] <= i_qent.r30;
        end
    end

    // one restoring quotient bit per stage
    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
        logic [REM_W:0] w_rem2;
        logic           w_ge;
        assign w_rem2 = {r_rem[k-1], 1'b0};
        assign w_ge   = w_rem2 >= {2'b00, r_den[k-1]};
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem[k] <= w_ge ? REM_W'(w_rem2 - {2'b00, r_den[k-1]})
                                 : w_rem2[REM_W-1:0];
                r_quo[k] <= {r_quo[k-1][DIV_STEPS-2:0], w_ge};
                r_den[k] <= r_den[k-1];
            end
        end
    end

    // s, with the very-short-distance clamp
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s   <= r_pl[DIV_STEPS].tiny ? S_CLAMP : {1'b0, r_quo[DIV_STEPS]};
            r_sd1 <= r_s;
            r_sd2 <= r_sd1;
        end
    end

    // s^2, then s^3 and s^4
    wcapf_mul u_mul_s2 (.i_clk, .i_en(en), .i_a(MUL_W'(r_s)), .i_b(MUL_W'(r_s)), .o_p(w_pa));
    assign w_s2 = w_pa[95:32];
    wcapf_mul u_mul_s3 (.i_clk, .i_en(en), .i_a(w_s2), .i_b(MUL_W'(r_sd2)), .o_p(w_pb));
    wcapf_mul u_mul_s4 (.i_clk, .i_en(en), .i_a(w_s2), .i_b(w_s2), .o_p(w_pc));
    assign w_s3 = w_pb[95:32];
    assign w_s4 = w_pc[95:32];

    // u = 2 s^3 - 1 in Q.32, kept as sign and magnitude
    assign w_s3x2 = {w_s3[MUL_W-2:0], 1'b0};
    assign w_uneg = w_s3[MUL_W-1:31] == '0;
    assign w_um   = w_uneg ? (MUL_W'(64'h1_0000_0000) - w_s3x2)
                           : (w_s3x2 - MUL_W'(64'h1_0000_0000));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_um <= w_um[UM_W-1:0];
            r_s4 <= w_s4;
        end
    end

    // energy = u^2, G = 24 s^4 |u|
    wcapf_mul u_mul_e (.i_clk, .i_en(en), .i_a(MUL_W'(r_um)), .i_b(MUL_W'(r_um)), .o_p(w_pd));
    wcapf_mul u_mul_g (.i_clk, .i_en(en), .i_a(r_s4), .i_b(MUL_W'(r_um)), .o_p(w_pe));
    assign w_eclip = w_pd[PROD_W-1:80] != '0;
    assign w_t     = w_pe[111:48];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g <= (w_t << 4) + (w_t << 3);
        end
    end

    // force magnitudes G * |w|
    for (genvar c = 0; c < 3; c++) begin : g_fmul
        wcapf_mul u_mul_f (.i_clk, .i_en(en), .i_a(r_g),
                           .i_b(MUL_W'(r_pl[ST_G].mag[c])), .o_p(w_pf[c]));
    end

    // payload pipe; a few stages fold in results
    always_comb begin
        n_pl[0].mag    = i_qent.mag;
        n_pl[0].wneg   = i_qent.wneg;
        n_pl[0].cut    = i_qent.cut;
        n_pl[0].tiny   = i_qent.tiny;
        n_pl[0].uneg   = 1'b0;
        n_pl[0].energy = '0;
        n_pl[0].eclip  = 1'b0;
        for (int k = 1; k <= ST_LAST; k++) begin
            n_pl[k] = r_pl[k-1];
        end
        n_pl[ST_U].uneg   = w_uneg;
        n_pl[ST_G].energy = w_eclip ? '1 : w_pd[79:48];
        n_pl[ST_G].eclip  = w_eclip;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k <= ST_LAST; k++) begin
                r_pl[k] <= n_pl[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[ST_LAST-1:0], i_q_valid};
        end
    end

    // sign and saturation; cutoff gating is applied in the output register
    always_comb begin
        logic neg;
        n_clip = r_pl[ST_LAST].eclip;
        for (int c = 0; c < 3; c++) begin
            w_mhi[c] = w_pf[c] >> POS_FRAC_BITS;
            neg      = r_pl[ST_LAST].uneg != r_pl[ST_LAST].wneg[c];
            if (w_mhi[c] == '0) begin
                n_force[c] = '0;
            end else if (!neg) begin
                if (w_mhi[c] > PROD_W'(32'h7FFF_FFFF)) begin
                    n_force[c] = 32'h7FFF_FFFF;
                    n_clip     = 1'b1;
                end else begin
                    n_force[c] = w_mhi[c][OUT_W-1:0];
                end
            end else begin
                if (w_mhi[c] > PROD_W'(32'h8000_0000)) begin
                    n_force[c] = 32'h8000_0000;
                    n_clip     = 1'b1;
                end else begin
                    n_force[c] = -w_mhi[c][OUT_W-1:0];
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cut    <= r_pl[ST_LAST].cut;
            r_force  <= r_pl[ST_LAST].cut ? n_force : '0;
            r_energy <= r_pl[ST_LAST].cut ? r_pl[ST_LAST].energy : '0;
            r_clip   <= r_pl[ST_LAST].cut && n_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (en) begin
            r_ovalid <= r_v[ST_LAST];
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.force_x     = r_force[0];
    assign o_out.force_y     = r_force[1];
    assign o_out.force_z     = r_force[2];
    assign o_out.pair_energy = r_energy;
    assign o_out.in_cutoff   = r_cut;
    assign o_out.clipped     = r_clip;

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.in_cutoff) |->
        (o_out.force_x == '0 && o_out.force_y == '0 && o_out.force_z == '0 &&
         o_out.pair_energy == '0 && !o_out.clipped))
        else $error("pair outside cutoff gave nonzero result");
endmodule

@@ rtl/wca_pair_force_min_image.sv @@
`timescale 1ns / 1ps
// Top level of the WCA pair force block: front, queue and back.
// Depends on wcapf_pkg, wcapf_in_if, wcapf_out_if, wcapf_front, wcapf_queue, wcapf_back.
//
// Takes one pair difference (Q8.24) per beat, wraps it to the minimum image
// with the box registers, and returns the WCA force (Q16.16 per axis) and
// pair energy (Q16.16), both saturating with a clipped flag; pairs outside
// the squared cutoff 2^(1/3) return zeros with in_cutoff low. One pair is accepted
// every cycle while the output side keeps taking beats. A pair passes through
// four front stages, the four-entry queue, the divider entry register,
// 38 stages of the reciprocal divider (one quotient bit each) and twelve
// stages of the multiplier chain up to the output register. Box registers must
// be written by the user through the config port only while no pair is in
// flight; the block itself does not enforce this.
module wca_pair_force_min_image import wcapf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BOX_W-1:0]     i_cfg_data,
    wcapf_in_if.sink             i_in,
    wcapf_out_if.source          o_out
);
    logic  q_push, q_full, q_valid, q_pop;
    t_qent q_in, q_out;

    wcapf_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in, .o_push(q_push), .o_qent(q_in), .i_q_full(q_full)
    );

    wcapf_queue u_queue (
        .i_clk, .i_rst_n, .i_push(q_push), .i_qent(q_in), .o_full(q_full),
        .o_valid(q_valid), .o_qent(q_out), .i_pop(q_pop)
    );

    wcapf_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .i_qent(q_out), .o_pop(q_pop),
        .o_out
    );
endmodule
